/* hdl/ltc_pkg.sv */
// shared types, token table and class codes for the token classifier
`default_nettype none
package ltc_pkg;

	localparam int ENTRY_COUNT  = 13;
	localparam int ENTRY_MAXLEN = 5;

	typedef enum logic [3:0] {
		CLS_SPACE   = 4'd0,
		CLS_LET     = 4'd1,
		CLS_WHERE   = 4'd2,
		CLS_FORCE   = 4'd3,
		CLS_NULL    = 4'd4,
		CLS_EQUALS  = 4'd5,
		CLS_COPEN   = 4'd6,
		CLS_CCLOSE  = 4'd7,
		CLS_LOPEN   = 4'd8,
		CLS_LCLOSE  = 4'd9,
		CLS_NUMBER  = 4'd10,
		CLS_NAME    = 4'd11,
		CLS_ERROR   = 4'd12
	} tok_class_t;

	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_DOT   = 8'h2E;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;

	// fixed token table, zero padded
	localparam logic [7:0] ENTRY_TEXT [ENTRY_COUNT][ENTRY_MAXLEN] = '{
		'{8'h0A, 8'h00, 8'h00, 8'h00, 8'h00},
		'{8'h09, 8'h00, 8'h00, 8'h00, 8'h00},
		'{8'h0D, 8'h00, 8'h00, 8'h00, 8'h00},
		'{8'h20, 8'h00, 8'h00, 8'h00, 8'h00},
		'{8'h6C, 8'h65, 8'h74, 8'h00, 8'h00},
		'{8'h77, 8'h68, 8'h65, 8'h72, 8'h65},
		'{8'h66, 8'h6F, 8'h72, 8'h63, 8'h65},
		'{8'h6E, 8'h75, 8'h6C, 8'h6C, 8'h00},
		'{8'h3D, 8'h00, 8'h00, 8'h00, 8'h00},
		'{8'h28, 8'h00, 8'h00, 8'h00, 8'h00},
		'{8'h29, 8'h00, 8'h00, 8'h00, 8'h00},
		'{8'h5B, 8'h00, 8'h00, 8'h00, 8'h00},
		'{8'h5D, 8'h00, 8'h00, 8'h00, 8'h00}
	};

	localparam logic [2:0] ENTRY_LEN [ENTRY_COUNT] = '{
		3'd1, 3'd1, 3'd1, 3'd1, 3'd3, 3'd5, 3'd5, 3'd4, 3'd1, 3'd1, 3'd1, 3'd1, 3'd1
	};

	localparam tok_class_t ENTRY_CLASS [ENTRY_COUNT] = '{
		CLS_SPACE, CLS_SPACE, CLS_SPACE, CLS_SPACE, CLS_LET, CLS_WHERE, CLS_FORCE,
		CLS_NULL, CLS_EQUALS, CLS_COPEN, CLS_CCLOSE, CLS_LOPEN, CLS_LCLOSE
	};

	// one classified token travelling from the front to the queue
	typedef struct packed {
		logic       valid;
		tok_class_t cls;
	} ltc_beat_t;

endpackage
`default_nettype wire

/* hdl/ltc_front.sv */
// front end: per-byte table match and number/name tracking, emits a class on the last byte
`default_nettype none
module ltc_front (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               push,
	input  wire logic               full,
	input  wire logic [7:0]         char_byte,
	input  wire logic               last_byte,
	output ltc_pkg::ltc_beat_t      beat
);

	logic [2:0]                       pos_q;
	logic [ltc_pkg::ENTRY_COUNT-1:0]  mask_q;
	logic                             num_ok_q;
	logic                             dot_seen_q;
	logic                             first_dig_q;

	logic                             accept;
	logic                             is_dig;
	logic                             is_sign;
	logic [ltc_pkg::ENTRY_COUNT-1:0]  mask_nxt;
	logic                             num_ok_nxt;
	logic                             dot_seen_nxt;
	logic                             first_dig_nxt;
	logic [ltc_pkg::ENTRY_COUNT-1:0]  hit;
	ltc_pkg::tok_class_t              cls;

	assign accept  = push && !full;
	assign is_dig  = (char_byte >= ltc_pkg::CH_ZERO) && (char_byte <= ltc_pkg::CH_NINE);
	assign is_sign = (char_byte == ltc_pkg::CH_PLUS) || (char_byte == ltc_pkg::CH_MINUS);

	always_comb begin
		for (int e = 0; e < ltc_pkg::ENTRY_COUNT; e++) begin
			logic keep;
			keep = 1'b0;
			for (int k = 0; k < ltc_pkg::ENTRY_MAXLEN; k++) begin
				if (pos_q == 3'(k) && 3'(k) < ltc_pkg::ENTRY_LEN[e]
						&& ltc_pkg::ENTRY_TEXT[e][k] == char_byte) begin
					keep = 1'b1;
				end
			end
			mask_nxt[e] = mask_q[e] && keep;
			hit[e]      = mask_nxt[e] && (ltc_pkg::ENTRY_LEN[e] == pos_q + 3'd1);
		end
	end

	always_comb begin
		num_ok_nxt    = num_ok_q;
		dot_seen_nxt  = dot_seen_q;
		first_dig_nxt = first_dig_q || (pos_q == 3'd0 && is_dig);
		if (!is_dig) begin
			if (char_byte == ltc_pkg::CH_DOT) begin
				// one inner dot only
				if (dot_seen_q || pos_q == 3'd0 || last_byte) begin
					num_ok_nxt = 1'b0;
				end else begin
					dot_seen_nxt = 1'b1;
				end
			end else if (pos_q != 3'd0 || !is_sign) begin
				num_ok_nxt = 1'b0;
			end
		end
	end

	// lowest table entry wins, then number, name, error
	always_comb begin
		if (num_ok_nxt) begin
			cls = ltc_pkg::CLS_NUMBER;
		end else if (!first_dig_nxt) begin
			cls = ltc_pkg::CLS_NAME;
		end else begin
			cls = ltc_pkg::CLS_ERROR;
		end
		for (int e = ltc_pkg::ENTRY_COUNT - 1; e >= 0; e--) begin
			if (hit[e]) begin
				cls = ltc_pkg::ENTRY_CLASS[e];
			end
		end
	end

	assign beat.valid = accept && last_byte;
	assign beat.cls   = cls;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q       <= 3'd0;
			mask_q      <= '1;
			num_ok_q    <= 1'b1;
			dot_seen_q  <= 1'b0;
			first_dig_q <= 1'b0;
		end else if (accept) begin
			if (last_byte) begin
				pos_q       <= 3'd0;
				mask_q      <= '1;
				num_ok_q    <= 1'b1;
				dot_seen_q  <= 1'b0;
				first_dig_q <= 1'b0;
			end else begin
				if (pos_q != 3'd7) begin
					pos_q <= pos_q + 3'd1;
				end
				mask_q      <= mask_nxt;
				num_ok_q    <= num_ok_nxt;
				dot_seen_q  <= dot_seen_nxt;
				first_dig_q <= first_dig_nxt;
			end
		end
	end

endmodule
`default_nettype wire

/* hdl/ltc_queue.sv */
// short class queue between the front end and the result stage
`default_nettype none
module ltc_queue #(
	parameter int DEPTH = 4
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire ltc_pkg::ltc_beat_t wr,
	input  wire logic               rd,
	output logic                    full,
	output logic                    nonempty,
	output ltc_pkg::tok_class_t     rd_cls
);

	localparam int PtrW = $clog2(DEPTH);
	localparam int CntW = $clog2(DEPTH + 1);

	ltc_pkg::tok_class_t  store_q [DEPTH];
	logic [PtrW-1:0]      wr_ptr_q;
	logic [PtrW-1:0]      rd_ptr_q;
	logic [CntW-1:0]      count_q;
	logic                 do_wr;
	logic                 do_rd;

	assign full     = (count_q == CntW'(DEPTH));
	assign nonempty = (count_q != '0);
	assign do_wr    = wr.valid && !full;
	assign do_rd    = rd && nonempty;
	assign rd_cls   = store_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_wr) begin
			store_q[wr_ptr_q] <= wr.cls;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule
`default_nettype wire

/* hdl/ltc_back.sv */
// result stage: holds the oldest class on the output until it is popped
`default_nettype none
module ltc_back (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                q_nonempty,
	input  wire ltc_pkg::tok_class_t q_cls,
	output logic                     q_rd,
	input  wire logic                pop,
	output logic                     empty,
	output logic [3:0]               token_class
);

	logic                 out_valid_q;
	ltc_pkg::tok_class_t  cls_q;

	// refill whenever the output slot is free or being taken this cycle
	assign q_rd        = q_nonempty && (!out_valid_q || pop);
	assign empty       = !out_valid_q;
	assign token_class = 4'(cls_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (q_rd) begin
			out_valid_q <= 1'b1;
		end else if (pop) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (q_rd) begin
			cls_q <= q_cls;
		end
	end

endmodule
`default_nettype wire

/* hdl/lexer_token_classifier.sv */
// top level of the token classifier: front end, class queue and result stage
//
//  channel  | handshake        | beat
//  ---------+------------------+-------------------------------
//  input    | push / full      | char_byte[7:0], last_byte
//  result   | empty / pop      | token_class[3:0]
//
// one byte is taken per cycle unless full; a class is queued, then held in the output slot
// the front end only stalls (full) when the class queue is full
// a stalled result side holds the output slot, then the queue fills and full rises
// reset clears all token state, the queue and the output slot
`default_nettype none
module lexer_token_classifier #(
	parameter int QUEUE_DEPTH = 4
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        push,
	output logic             full,
	input  wire logic [7:0]  char_byte,
	input  wire logic        last_byte,
	output logic             empty,
	input  wire logic        pop,
	output logic [3:0]       token_class
);

	ltc_pkg::ltc_beat_t   beat;
	logic                 q_full;
	logic                 q_nonempty;
	logic                 q_rd;
	ltc_pkg::tok_class_t  q_cls;

	assign full = q_full;

	ltc_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (q_full),
		.char_byte (char_byte),
		.last_byte (last_byte),
		.beat      (beat)
	);

	ltc_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr       (beat),
		.rd       (q_rd),
		.full     (q_full),
		.nonempty (q_nonempty),
		.rd_cls   (q_cls)
	);

	ltc_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_nonempty  (q_nonempty),
		.q_cls       (q_cls),
		.q_rd        (q_rd),
		.pop         (pop),
		.empty       (empty),
		.token_class (token_class)
	);

endmodule
`default_nettype wire

/* tb/lexer_token_classifier_tb.sv */
// self-checking testbench for the token classifier: byte beats in, class codes out
`default_nettype none
module lexer_token_classifier_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CYCLE_LIMIT  = 200000;
	localparam int DRAIN_CYCLES = 10;
	localparam int RANDOM_BYTES = 425;
	localparam int HOLD_CYCLES  = 300;

	logic       clk;
	logic       arst_n;
	logic       push;
	logic       full;
	logic [7:0] char_byte;
	logic       last_byte;
	logic       empty;
	logic       pop;
	logic [3:0] token_class;

	// running copy of the token state
	logic [2:0]                      tok_pos;
	logic [ltc_pkg::ENTRY_COUNT-1:0] live_mask;
	bit                              num_ok;
	bit                              dot_seen;
	bit                              lead_digit;

	ltc_pkg::tok_class_t pending_cls[$];
	logic [7:0]          tok_buf[$];
	int                  errors;
	int                  cycles;
	int                  bytes_sent;
	int                  rx_hold;
	bit                  tx_idle_on;
	bit                  rx_idle_on;

	lexer_token_classifier dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (push),
		.full        (full),
		.char_byte   (char_byte),
		.last_byte   (last_byte),
		.empty       (empty),
		.pop         (pop),
		.token_class (token_class)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	task automatic clear_token();
		tok_pos    = '0;
		live_mask  = '1;
		num_ok     = 1'b1;
		dot_seen   = 1'b0;
		lead_digit = 1'b0;
	endtask

	// advance the token state by one byte; on the final byte queue the class it yields
	task automatic classify_byte(input logic [7:0] b, input logic fin);
		int                  pos;
		bit                  is_dig;
		bit                  hit;
		ltc_pkg::tok_class_t cls;
		pos = tok_pos;
		is_dig = (b >= ltc_pkg::CH_ZERO) && (b <= ltc_pkg::CH_NINE);
		for (int e = 0; e < ltc_pkg::ENTRY_COUNT; e++)
			if (pos >= ltc_pkg::ENTRY_LEN[e] || ltc_pkg::ENTRY_TEXT[e][pos] != b)
				live_mask[e] = 1'b0;
		if (pos == 0 && is_dig)
			lead_digit = 1'b1;
		if (!is_dig) begin
			if (b == ltc_pkg::CH_DOT) begin
				if (dot_seen || pos == 0 || fin)
					num_ok = 1'b0;
				else
					dot_seen = 1'b1;
			end else if (pos != 0 || (b != ltc_pkg::CH_PLUS && b != ltc_pkg::CH_MINUS)) begin
				num_ok = 1'b0;
			end
		end
		// position saturates; past the longest table entry the rules only care whether a byte is the first
		if (pos < 7)
			tok_pos = tok_pos + 3'd1;
		if (fin) begin
			hit = 1'b0;
			cls = ltc_pkg::CLS_ERROR;
			for (int e = 0; e < ltc_pkg::ENTRY_COUNT; e++)
				if (!hit && live_mask[e] && ltc_pkg::ENTRY_LEN[e] == pos + 1) begin
					cls = ltc_pkg::ENTRY_CLASS[e];
					hit = 1'b1;
				end
			if (!hit) begin
				if (num_ok)
					cls = ltc_pkg::CLS_NUMBER;
				else if (!lead_digit)
					cls = ltc_pkg::CLS_NAME;
				else
					cls = ltc_pkg::CLS_ERROR;
			end
			pending_cls.push_back(cls);
			clear_token();
		end
	endtask

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 70)
			return 0;
		else if (r < 95)
			return $urandom_range(1, 3);
		else
			return $urandom_range(10, 30);
	endfunction

	function automatic logic [7:0] rand_digit();
		return ltc_pkg::CH_ZERO + 8'($urandom_range(0, 9));
	endfunction

	function automatic logic [7:0] rand_letter();
		return 8'h61 + 8'($urandom_range(0, 25));
	endfunction

	task automatic send_byte(input logic [7:0] b, input logic fin);
		int gap;
		@(negedge clk);
		push <= 1'b1;
		char_byte <= b;
		last_byte <= fin;
		do @(posedge clk); while (full);
		classify_byte(b, fin);
		bytes_sent++;
		gap = tx_idle_on ? pick_gap() : 0;
		if (gap > 0) begin
			@(negedge clk);
			push <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
	endtask

	task automatic send_token();
		foreach (tok_buf[i])
			send_byte(tok_buf[i], i == tok_buf.size() - 1);
		tok_buf.delete();
	endtask

	task automatic load_text(input string s);
		for (int k = 0; k < s.len(); k++)
			tok_buf.push_back(s[k]);
	endtask

	task automatic load_entry(input int e);
		for (int k = 0; k < ltc_pkg::ENTRY_LEN[e]; k++)
			tok_buf.push_back(ltc_pkg::ENTRY_TEXT[e][k]);
	endtask

	task automatic wait_drained();
		while (pending_cls.size() != 0)
			@(posedge clk);
	endtask

	task automatic test_table();
		for (int e = 0; e < ltc_pkg::ENTRY_COUNT; e++) begin
			load_entry(e);
			send_token();
		end
	endtask

	task automatic test_special();
		string words[] = '{"+", "-", "7", "-3.14", "+.5", "1.", ".5", "1..2", "12.3.4",
			"9x", "x9", "le", "letter", "nul", "abcdefghijk", "98765432101234", "=="};
		foreach (words[i]) begin
			load_text(words[i]);
			send_token();
		end
		// byte extremes and non-ascii bytes inside names and numbers
		tok_buf.push_back(8'h00);
		send_token();
		tok_buf.push_back(8'hFF);
		send_token();
		tok_buf = '{8'h61, 8'hFF, 8'h80, 8'h62};
		send_token();
		tok_buf = '{8'h35, 8'hFF};
		send_token();
	endtask

	// receiver holds off while one-byte tokens keep coming, so full must rise
	task automatic test_backpressure();
		tx_idle_on = 1'b0;
		rx_hold = HOLD_CYCLES;
		repeat (24) begin
			tok_buf.push_back(8'($urandom_range(0, 255)));
			send_token();
		end
		tx_idle_on = 1'b1;
		@(negedge clk);
		push <= 1'b0;
		wait_drained();
	endtask

	task automatic test_random(input int n_bytes);
		int stop_at;
		int r;
		int n;
		logic [7:0] b;
		stop_at = bytes_sent + n_bytes;
		while (bytes_sent < stop_at) begin
			if ($urandom_range(0, 29) == 0)
				tx_idle_on = ~tx_idle_on;
			if ($urandom_range(0, 29) == 0)
				rx_idle_on = ~rx_idle_on;
			r = $urandom_range(0, 99);
			if (r < 15) begin
				load_entry($urandom_range(0, ltc_pkg::ENTRY_COUNT - 1));
			end else if (r < 30) begin
				// near misses of table entries
				load_entry($urandom_range(0, ltc_pkg::ENTRY_COUNT - 1));
				case ($urandom_range(0, 2))
					0: begin
						if (tok_buf.size() > 1)
							void'(tok_buf.pop_back());
						else
							tok_buf.push_back(rand_letter());
					end
					1: begin
						tok_buf.push_back(8'($urandom_range(0, 255)));
					end
					default: begin
						tok_buf[$urandom_range(0, tok_buf.size() - 1)] = 8'($urandom_range(0, 255));
					end
				endcase
			end else if (r < 55) begin
				n = $urandom_range(0, 8);
				if ($urandom_range(0, 3) == 0)
					tok_buf.push_back($urandom_range(0, 1) ? ltc_pkg::CH_PLUS : ltc_pkg::CH_MINUS);
				else if (n == 0)
					n = 1;
				for (int k = 0; k < n; k++)
					tok_buf.push_back(rand_digit());
				if (n >= 2 && $urandom_range(0, 2) == 0)
					tok_buf.insert($urandom_range(tok_buf.size() - n + 1, tok_buf.size() - 1),
						ltc_pkg::CH_DOT);
				// broken numbers: a stray byte or a trailing dot
				if ($urandom_range(0, 4) == 0) begin
					if ($urandom_range(0, 1))
						tok_buf.push_back(ltc_pkg::CH_DOT);
					else
						tok_buf[$urandom_range(0, tok_buf.size() - 1)] = 8'($urandom_range(0, 255));
				end
			end else if (r < 80) begin
				if ($urandom_range(0, 3) != 0) begin
					b = rand_letter();
				end else begin
					do b = 8'($urandom_range(0, 255));
					while (b >= ltc_pkg::CH_ZERO && b <= ltc_pkg::CH_NINE);
				end
				tok_buf.push_back(b);
				repeat ($urandom_range(0, 8)) begin
					case ($urandom_range(0, 2))
						0: tok_buf.push_back(rand_letter());
						1: tok_buf.push_back(rand_digit());
						default: tok_buf.push_back(8'($urandom_range(0, 255)));
					endcase
				end
			end else if (r < 92) begin
				repeat ($urandom_range(1, 8))
					tok_buf.push_back(8'($urandom_range(0, 255)));
			end else begin
				n = $urandom_range(8, 14);
				if ($urandom_range(0, 1)) begin
					repeat (n) tok_buf.push_back(rand_digit());
				end else begin
					repeat (n) tok_buf.push_back($urandom_range(0, 1) ? rand_letter() : rand_digit());
				end
			end
			send_token();
		end
	endtask

	initial begin : receiver
		int gap;
		gap = 0;
		pop = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(negedge clk);
			if (rx_hold > 0) begin
				rx_hold--;
				pop <= 1'b0;
			end else if (gap > 0) begin
				gap--;
				pop <= 1'b0;
			end else begin
				pop <= 1'b1;
				if (rx_idle_on)
					gap = pick_gap();
			end
		end
	end

	always @(posedge clk) begin : check_results
		ltc_pkg::tok_class_t want;
		if (arst_n && pop && !empty) begin
			if (pending_cls.size() == 0) begin
				$display("%0t: token_class expected none, got %0d", $time, token_class);
				errors++;
			end else begin
				want = pending_cls.pop_front();
				if (token_class !== want) begin
					$display("%0t: token_class expected %0d (%s), got %0d",
						$time, want, want.name(), token_class);
					errors++;
				end
			end
		end
	end

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		push = 1'b0;
		char_byte = '0;
		last_byte = 1'b0;
		errors = 0;
		cycles = 0;
		bytes_sent = 0;
		rx_hold = 0;
		tx_idle_on = 1'b1;
		rx_idle_on = 1'b1;
		clear_token();
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		test_table();
		test_special();
		test_backpressure();
		test_random(RANDOM_BYTES);
		@(negedge clk);
		push <= 1'b0;
		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
`default_nettype wire
